// File: design/apbc_pkg.sv
package apbc_pkg;

  localparam int RING_SAMPLES_DEF  = 65536;
  localparam int CHUNK_SAMPLES_DEF = 32;

  localparam logic [31:0] UNKNOWN_LEN = 32'hffff_ffff;

  localparam logic [17:0] RATE_RST     = 18'd16000;
  localparam logic [16:0] PREBUF_RST   = 17'd4096;
  localparam logic [14:0] LOUD_RST     = 15'd5200;
  localparam logic [14:0] QUIET_RST    = 15'd900;
  localparam logic [14:0] PEAK_MAX     = 15'h7fff;

  localparam logic [1:0] REG_RATE   = 2'd0;
  localparam logic [1:0] REG_PREBUF = 2'd1;
  localparam logic [1:0] REG_LOUD   = 2'd2;
  localparam logic [1:0] REG_QUIET  = 2'd3;

  typedef enum logic [2:0] {
    CMD_START  = 3'd0,
    CMD_WRITE  = 3'd1,
    CMD_FINISH = 3'd2,
    CMD_STOP   = 3'd3,
    CMD_PULL   = 3'd4,
    CMD_POLL   = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FMT   = 2'd1,
    STAT_STATE = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    STRM_IDLE      = 2'd0,
    STRM_BUFFERING = 2'd1,
    STRM_PLAYING   = 2'd2,
    STRM_DRAINED   = 2'd3
  } strm_t;

  typedef enum logic [1:0] {
    LVL_QUIET  = 2'd0,
    LVL_MEDIUM = 2'd1,
    LVL_LOUD   = 2'd2
  } level_t;

  typedef enum logic [2:0] {
    FSM_READY    = 3'd0,
    FSM_SCAN     = 3'd1,
    FSM_SCAN_END = 3'd2,
    FSM_FETCH    = 3'd3,
    FSM_EMIT     = 3'd4
  } fsm_t;

endpackage

// File: design/apbc_in_if.sv
interface apbc_in_if import apbc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic signed [15:0] sample;
  logic [31:0]        total_samples;
  logic [31:0]        sample_rate;

  modport source (output valid, command, sample, total_samples, sample_rate, input ready);
  modport sink   (input valid, command, sample, total_samples, sample_rate, output ready);
endinterface

// File: design/apbc_out_if.sv
interface apbc_out_if import apbc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               completion_event;
  logic               frame_valid;
  logic signed [15:0] frame_sample;
  logic               last;
  logic [1:0]         mouth_level;
  logic [1:0]         stream_state;
  logic               active;
  logic [31:0]        underruns;

  modport source (output valid, status, completion_event, frame_valid, frame_sample, last,
                  mouth_level, stream_state, active, underruns, input ready);
  modport sink   (input valid, status, completion_event, frame_valid, frame_sample, last,
                  mouth_level, stream_state, active, underruns, output ready);
endinterface

// File: design/audio_playback_buffer_controller.sv
// Mono 16-bit playback ring with a stream state machine (idle, buffering, playing,
// drained). Commands arrive one transaction at a time on in_ch; every command gives one
// result on out_ch, except a pull that plays frames, which gives one result per frame.
// The next command is taken as soon as the previous result leaves the output register.
// A pull that plays n frames (n = min(fill, CHUNK_SAMPLES)) sweeps the read port of the
// sample memory twice: first for the chunk peak that sets mouth_level, then to fetch
// and emit each frame, where each emit waits for the output register to be free.
// The sample memory needs no clearing after reset.
module audio_playback_buffer_controller
  import apbc_pkg::*;
#(
  parameter int RING_SAMPLES  = RING_SAMPLES_DEF,
  parameter int CHUNK_SAMPLES = CHUNK_SAMPLES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  apbc_in_if.sink     in_ch,
  apbc_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PTR_W  = $clog2(RING_SAMPLES);
  localparam int FILL_W = $clog2(RING_SAMPLES + 1);
  localparam int CNT_W  = $clog2(CHUNK_SAMPLES + 1);

  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(RING_SAMPLES - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(RING_SAMPLES);
  localparam logic [FILL_W-1:0] FILL_CHNK = FILL_W'(CHUNK_SAMPLES);
  localparam logic [CNT_W-1:0]  CNT_CHNK  = CNT_W'(CHUNK_SAMPLES);
  localparam logic [31:0]       LEN_MAX   = 32'(RING_SAMPLES);

  logic [17:0] rate_r;
  logic [16:0] prebuf_r;
  logic [14:0] loud_r;
  logic [14:0] quiet_r;

  logic [15:0] mem [RING_SAMPLES];
  logic [15:0] rdata_r;

  fsm_t              fsm_r, fsm_nxt;
  strm_t             strm_r, strm_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  scan_ptr_r, scan_ptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [31:0]       exp_r, exp_nxt;
  logic [31:0]       recv_r, recv_nxt;
  logic [31:0]       und_r, und_nxt;
  logic              end_r, end_nxt;
  level_t            lvl_r, lvl_nxt;
  logic              pend_r, pend_nxt;
  logic [CNT_W-1:0]  scan_cnt_r, scan_cnt_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic              rd_vld_r;
  logic [14:0]       peak_r, peak_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           status_r, status_nxt;
  logic              event_r, event_nxt;
  logic              fval_r, fval_nxt;
  logic [15:0]       fsmp_r, fsmp_nxt;
  logic              last_r, last_nxt;

  logic              in_ready;
  logic              acc;
  logic              emit_load;
  logic              ren;
  logic [PTR_W-1:0]  raddr;
  logic              mem_we;
  cmd_t              cmd;
  logic              known_done;
  logic              stream_ready;
  logic              play_now;
  logic              pull_frames;
  logic [CNT_W-1:0]  chunk_n;
  logic [15:0]       neg_smp;
  logic [14:0]       mag;
  logic [14:0]       peak_new;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  // configuration port
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_RATE:   prdata = {14'd0, rate_r};
      REG_PREBUF: prdata = {15'd0, prebuf_r};
      REG_LOUD:   prdata = {17'd0, loud_r};
      REG_QUIET:  prdata = {17'd0, quiet_r};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r   <= RATE_RST;
      prebuf_r <= PREBUF_RST;
      loud_r   <= LOUD_RST;
      quiet_r  <= QUIET_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_RATE:   rate_r   <= pwdata[17:0];
        REG_PREBUF: prebuf_r <= pwdata[16:0];
        REG_LOUD:   loud_r   <= pwdata[14:0];
        REG_QUIET:  quiet_r  <= pwdata[14:0];
        default:    ;
      endcase
    end
  end

  // pull decision
  assign cmd          = cmd_t'(in_ch.command);
  assign known_done   = (exp_r != UNKNOWN_LEN) && end_r && (recv_r == exp_r);
  assign stream_ready = (exp_r == UNKNOWN_LEN) &&
                        ((32'(fill_r) >= 32'(prebuf_r)) || (end_r && (fill_r != '0)));
  assign play_now     = (strm_r == STRM_PLAYING) ||
                        ((strm_r == STRM_BUFFERING) && (known_done || stream_ready));
  assign pull_frames  = (cmd == CMD_PULL) && play_now && (fill_r != '0);
  assign chunk_n      = (fill_r < FILL_CHNK) ? fill_r[CNT_W-1:0] : CNT_CHNK;

  // chunk peak
  assign neg_smp  = 16'(-rdata_r);
  assign mag      = rdata_r[15] ? ((rdata_r == 16'h8000) ? PEAK_MAX : neg_smp[14:0])
                                : rdata_r[14:0];
  assign peak_new = (rd_vld_r && (mag > peak_r)) ? mag : peak_r;

  // control outputs
  always_comb begin
    in_ready  = (fsm_r == FSM_READY) && (!out_valid_r || out_ch.ready);
    acc       = in_ch.valid && in_ready;
    emit_load = (fsm_r == FSM_EMIT) && (!out_valid_r || out_ch.ready);
    ren       = (fsm_r == FSM_SCAN) || (fsm_r == FSM_FETCH);
    raddr     = (fsm_r == FSM_SCAN) ? scan_ptr_r : rd_ptr_r;
  end

  // next state
  always_comb begin
    fsm_nxt = fsm_r;
    case (fsm_r)
      FSM_READY:    if (acc && pull_frames) fsm_nxt = FSM_SCAN;
      FSM_SCAN:     if (scan_cnt_r == CNT_W'(1)) fsm_nxt = FSM_SCAN_END;
      FSM_SCAN_END: fsm_nxt = FSM_FETCH;
      FSM_FETCH:    fsm_nxt = FSM_EMIT;
      FSM_EMIT: begin
        if (emit_load) fsm_nxt = (rem_r == '0) ? FSM_READY : FSM_FETCH;
      end
      default:      fsm_nxt = FSM_READY;
    endcase
  end

  // datapath
  always_comb begin
    strm_nxt     = strm_r;
    rd_ptr_nxt   = rd_ptr_r;
    wr_ptr_nxt   = wr_ptr_r;
    scan_ptr_nxt = scan_ptr_r;
    fill_nxt     = fill_r;
    exp_nxt      = exp_r;
    recv_nxt     = recv_r;
    und_nxt      = und_r;
    end_nxt      = end_r;
    lvl_nxt      = lvl_r;
    pend_nxt     = pend_r;
    scan_cnt_nxt = scan_cnt_r;
    rem_nxt      = rem_r;
    peak_nxt     = peak_new;
    mem_we       = 1'b0;
    status_nxt   = status_r;
    event_nxt    = event_r;
    fval_nxt     = fval_r;
    fsmp_nxt     = fsmp_r;
    last_nxt     = last_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;

    if (acc) begin
      status_nxt = STAT_OK;
      event_nxt  = 1'b0;
      fval_nxt   = 1'b0;
      fsmp_nxt   = '0;
      last_nxt   = 1'b1;
      case (cmd)
        CMD_START: begin
          if ((in_ch.sample_rate != {14'd0, rate_r}) || (in_ch.total_samples == '0) ||
              ((in_ch.total_samples != UNKNOWN_LEN) && (in_ch.total_samples > LEN_MAX))) begin
            status_nxt = STAT_FMT;
          end else begin
            strm_nxt   = STRM_BUFFERING;
            rd_ptr_nxt = '0;
            wr_ptr_nxt = '0;
            fill_nxt   = '0;
            end_nxt    = 1'b0;
            lvl_nxt    = LVL_QUIET;
            pend_nxt   = 1'b0;
            exp_nxt    = in_ch.total_samples;
            recv_nxt   = '0;
            und_nxt    = '0;
          end
        end
        CMD_WRITE: begin
          if (!((strm_r == STRM_BUFFERING) || (strm_r == STRM_PLAYING)) || end_r) begin
            status_nxt = STAT_STATE;
          end else if ((exp_r != UNKNOWN_LEN) && (recv_r == exp_r)) begin
            status_nxt = STAT_FMT;
          end else if (fill_r == FILL_FULL) begin
            status_nxt = STAT_FULL;
          end else begin
            mem_we     = 1'b1;
            wr_ptr_nxt = ptr_inc(wr_ptr_r);
            fill_nxt   = fill_r + FILL_W'(1);
            recv_nxt   = recv_r + 32'd1;
          end
        end
        CMD_FINISH: begin
          if (!((strm_r == STRM_BUFFERING) || (strm_r == STRM_PLAYING))) begin
            status_nxt = STAT_STATE;
          end else if ((exp_r != UNKNOWN_LEN) && (recv_r != exp_r)) begin
            status_nxt = STAT_FMT;
            strm_nxt   = STRM_IDLE;
            rd_ptr_nxt = '0;
            wr_ptr_nxt = '0;
            fill_nxt   = '0;
            end_nxt    = 1'b0;
            lvl_nxt    = LVL_QUIET;
            pend_nxt   = 1'b0;
          end else begin
            end_nxt = 1'b1;
          end
        end
        CMD_STOP: begin
          strm_nxt   = STRM_IDLE;
          rd_ptr_nxt = '0;
          wr_ptr_nxt = '0;
          fill_nxt   = '0;
          end_nxt    = 1'b0;
          lvl_nxt    = LVL_QUIET;
          pend_nxt   = 1'b0;
        end
        CMD_PULL: begin
          if (!play_now) begin
            if ((strm_r == STRM_BUFFERING) && end_r && (fill_r == '0)) begin
              strm_nxt = STRM_DRAINED;
              pend_nxt = 1'b1;
            end
          end else if (fill_r == '0) begin
            if (end_r) begin
              strm_nxt = STRM_DRAINED;
              pend_nxt = 1'b1;
            end else begin
              und_nxt  = und_r + 32'd1;
              strm_nxt = STRM_BUFFERING;
            end
          end else begin
            strm_nxt     = STRM_PLAYING;
            fill_nxt     = fill_r - FILL_W'(chunk_n);
            scan_ptr_nxt = rd_ptr_r;
            scan_cnt_nxt = chunk_n;
            rem_nxt      = chunk_n;
            peak_nxt     = '0;
          end
        end
        CMD_POLL: begin
          if (pend_r) begin
            event_nxt = 1'b1;
            pend_nxt  = 1'b0;
            strm_nxt  = STRM_IDLE;
            lvl_nxt   = LVL_QUIET;
          end
        end
        default: ;
      endcase
      if (!pull_frames) out_valid_nxt = 1'b1;
    end

    case (fsm_r)
      FSM_SCAN: begin
        scan_ptr_nxt = ptr_inc(scan_ptr_r);
        scan_cnt_nxt = scan_cnt_r - CNT_W'(1);
      end
      FSM_SCAN_END: begin
        if (peak_new >= loud_r) lvl_nxt = LVL_LOUD;
        else if (peak_new >= quiet_r) lvl_nxt = LVL_MEDIUM;
        else lvl_nxt = LVL_QUIET;
      end
      FSM_FETCH: begin
        rd_ptr_nxt = ptr_inc(rd_ptr_r);
        rem_nxt    = rem_r - CNT_W'(1);
      end
      FSM_EMIT: begin
        if (emit_load) begin
          out_valid_nxt = 1'b1;
          status_nxt    = STAT_OK;
          event_nxt     = 1'b0;
          fval_nxt      = 1'b1;
          fsmp_nxt      = rdata_r;
          last_nxt      = (rem_r == '0);
        end
      end
      default: ;
    endcase
  end

  // sample memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_ptr_r] <= in_ch.sample;
    if (ren) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= FSM_READY;
      strm_r      <= STRM_IDLE;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      fill_r      <= '0;
      exp_r       <= UNKNOWN_LEN;
      recv_r      <= '0;
      und_r       <= '0;
      end_r       <= 1'b0;
      lvl_r       <= LVL_QUIET;
      pend_r      <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fsm_r       <= fsm_nxt;
      strm_r      <= strm_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      fill_r      <= fill_nxt;
      exp_r       <= exp_nxt;
      recv_r      <= recv_nxt;
      und_r       <= und_nxt;
      end_r       <= end_nxt;
      lvl_r       <= lvl_nxt;
      pend_r      <= pend_nxt;
      rd_vld_r    <= (fsm_r == FSM_SCAN);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_ptr_r <= scan_ptr_nxt;
    scan_cnt_r <= scan_cnt_nxt;
    rem_r      <= rem_nxt;
    peak_r     <= peak_nxt;
    status_r   <= status_nxt;
    event_r    <= event_nxt;
    fval_r     <= fval_nxt;
    fsmp_r     <= fsmp_nxt;
    last_r     <= last_nxt;
  end

  assign in_ch.ready             = in_ready;
  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = status_r;
  assign out_ch.completion_event = event_r;
  assign out_ch.frame_valid      = fval_r;
  assign out_ch.frame_sample     = fsmp_r;
  assign out_ch.last             = last_r;
  assign out_ch.mouth_level      = lvl_r;
  assign out_ch.stream_state     = strm_r;
  assign out_ch.active           = (strm_r == STRM_BUFFERING) || (strm_r == STRM_PLAYING);
  assign out_ch.underruns        = und_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL)
    else $error("fill count above ring size");

  a_frames_playing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && fval_r) |-> (strm_r == STRM_PLAYING))
    else $error("frame emitted outside playing state");

  a_busy_playing: assert property (@(posedge clk) disable iff (!rst_n)
    (fsm_r != FSM_READY) |-> (strm_r == STRM_PLAYING))
    else $error("chunk sequencer busy outside playing state");

  a_scan_holds_rd: assert property (@(posedge clk) disable iff (!rst_n)
    ((fsm_r == FSM_SCAN) || (fsm_r == FSM_SCAN_END)) |=> $stable(rd_ptr_r))
    else $error("read pointer moved during peak scan");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import apbc_pkg::*;

  localparam int RING        = RING_SAMPLES_DEF;
  localparam int CHUNK       = CHUNK_SAMPLES_DEF;
  localparam int PTR_W       = $clog2(RING);
  localparam int MAX_REPORTS = 10;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [1:0]  status;
    logic        completion;
    logic        frame_valid;
    logic [15:0] frame;
    logic        last;
    logic [1:0]  level;
    logic [1:0]  state;
    logic        active;
    logic [31:0] underruns;
  } playback_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  apbc_in_if  in_ch();
  apbc_out_if out_ch();

  audio_playback_buffer_controller dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  // predicted block state
  logic [17:0]      sup_rate;
  logic [16:0]      prebuf_need;
  logic [14:0]      loud_min;
  logic [14:0]      quiet_min;
  logic [15:0]      sample_ring [RING];
  logic [PTR_W-1:0] m_rd;
  logic [PTR_W-1:0] m_wr;
  logic [16:0]      m_fill;
  logic [31:0]      m_expected;
  logic [31:0]      m_received;
  logic [31:0]      m_underruns;
  strm_t            m_state;
  logic             m_end_seen;
  logic [1:0]       m_level;
  logic             m_pending;

  playback_result_t expected_results[$];
  int  mismatches = 0;
  int  sent_items = 0;
  bit  no_idle = 1'b0;
  int  holds_asked = 0;
  int  holds_granted = 0;
  int  hold_left = 0;
  int  stall_cycles = 0;

  function automatic bit count_mismatch();
    mismatches++;
    return mismatches <= MAX_REPORTS;
  endfunction

  function automatic string show(playback_result_t r);
    return $sformatf("st=%0d ev=%0d fv=%0d smp=%h last=%0d lvl=%0d ss=%0d act=%0d und=%0d",
                     r.status, r.completion, r.frame_valid, r.frame, r.last, r.level,
                     r.state, r.active, r.underruns);
  endfunction

  function automatic void clear_stream();
    m_state    = STRM_IDLE;
    m_rd       = '0;
    m_wr       = '0;
    m_fill     = '0;
    m_end_seen = 1'b0;
    m_level    = LVL_QUIET;
    m_pending  = 1'b0;
  endfunction

  function automatic void reset_prediction();
    sup_rate    = RATE_RST;
    prebuf_need = PREBUF_RST;
    loud_min    = LOUD_RST;
    quiet_min   = QUIET_RST;
    clear_stream();
    m_expected  = UNKNOWN_LEN;
    m_received  = '0;
    m_underruns = '0;
  endfunction

  function automatic void push_result(logic [1:0] st, logic ev, logic fv, logic [15:0] smp,
                                      logic lst);
    playback_result_t r;
    r.status      = st;
    r.completion  = ev;
    r.frame_valid = fv;
    r.frame       = smp;
    r.last        = lst;
    r.level       = m_level;
    r.state       = m_state;
    r.active      = (m_state == STRM_BUFFERING) || (m_state == STRM_PLAYING);
    r.underruns   = m_underruns;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_pull();
    logic        known_done;
    logic        stream_ready;
    int          n;
    logic [16:0] mag;
    logic [16:0] peak;
    logic [15:0] chunk [CHUNK];
    peak = '0;
    if (m_state == STRM_BUFFERING) begin
      known_done = (m_expected != UNKNOWN_LEN) && m_end_seen && (m_received == m_expected);
      stream_ready = (m_expected == UNKNOWN_LEN) &&
                     ((m_fill >= prebuf_need) || (m_end_seen && m_fill != 0));
      if (known_done || stream_ready) begin
        m_state = STRM_PLAYING;
      end else begin
        if (m_end_seen && m_fill == 0) begin
          m_state   = STRM_DRAINED;
          m_pending = 1'b1;
        end
        push_result(STAT_OK, 1'b0, 1'b0, '0, 1'b1);
        return;
      end
    end
    if (m_state != STRM_PLAYING) begin
      push_result(STAT_OK, 1'b0, 1'b0, '0, 1'b1);
      return;
    end
    if (m_fill == 0) begin
      if (m_end_seen) begin
        m_state   = STRM_DRAINED;
        m_pending = 1'b1;
      end else begin
        m_underruns = m_underruns + 32'd1;
        m_state     = STRM_BUFFERING;
      end
      push_result(STAT_OK, 1'b0, 1'b0, '0, 1'b1);
      return;
    end
    n = (m_fill < CHUNK) ? int'(m_fill) : CHUNK;
    for (int i = 0; i < n; i++) begin
      chunk[i] = sample_ring[m_rd];
      m_rd = (m_rd == PTR_W'(RING - 1)) ? '0 : m_rd + PTR_W'(1);
      mag = chunk[i][15] ? (17'h10000 - {1'b0, chunk[i]}) : {1'b0, chunk[i]};
      if (mag > 17'd32767) mag = 17'd32767;
      if (mag > peak) peak = mag;
    end
    m_fill = m_fill - 17'(n);
    m_level = (peak >= {2'b00, loud_min})  ? LVL_LOUD :
              (peak >= {2'b00, quiet_min}) ? LVL_MEDIUM : LVL_QUIET;
    for (int i = 0; i < n; i++)
      push_result(STAT_OK, 1'b0, 1'b1, chunk[i], (i + 1 == n));
  endfunction

  function automatic void predict_command(logic [2:0] c, logic [15:0] s, logic [31:0] tot,
                                          logic [31:0] rate);
    logic [1:0] st;
    logic       ev;
    st = STAT_OK;
    ev = 1'b0;
    case (c)
      CMD_START: begin
        if (rate != {14'd0, sup_rate} || tot == 0 ||
            (tot != UNKNOWN_LEN && tot > 32'(RING))) begin
          st = STAT_FMT;
        end else begin
          clear_stream();
          m_expected  = tot;
          m_received  = '0;
          m_underruns = '0;
          m_state     = STRM_BUFFERING;
        end
      end
      CMD_WRITE: begin
        if (!(m_state == STRM_BUFFERING || m_state == STRM_PLAYING) || m_end_seen) begin
          st = STAT_STATE;
        end else if (m_expected != UNKNOWN_LEN && m_expected == m_received) begin
          st = STAT_FMT;
        end else if (m_fill >= 17'(RING)) begin
          st = STAT_FULL;
        end else begin
          sample_ring[m_wr] = s;
          m_wr = (m_wr == PTR_W'(RING - 1)) ? '0 : m_wr + PTR_W'(1);
          m_fill = m_fill + 17'd1;
          m_received = m_received + 32'd1;
        end
      end
      CMD_FINISH: begin
        if (!(m_state == STRM_BUFFERING || m_state == STRM_PLAYING)) begin
          st = STAT_STATE;
        end else if (m_expected != UNKNOWN_LEN && m_received != m_expected) begin
          clear_stream();
          st = STAT_FMT;
        end else begin
          m_end_seen = 1'b1;
        end
      end
      CMD_STOP: clear_stream();
      CMD_PULL: begin
        predict_pull();
        return;
      end
      CMD_POLL: begin
        if (m_pending) begin
          ev        = 1'b1;
          m_pending = 1'b0;
          m_state   = STRM_IDLE;
          m_level   = LVL_QUIET;
        end
      end
      default: ;
    endcase
    push_result(st, ev, 1'b0, '0, 1'b1);
  endfunction

  function automatic logic [31:0] rate_now();
    return {14'd0, sup_rate};
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return ($urandom_range(1) == 0) ? 16'h0000 : 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(3))
      0: return 32'h0;
      1: return UNKNOWN_LEN;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_cmd(logic [2:0] c, logic [15:0] s, logic [31:0] tot, logic [31:0] rate);
    if (!no_idle && $urandom_range(99) < 7) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= c;
    in_ch.sample        <= s;
    in_ch.total_samples <= tot;
    in_ch.sample_rate   <= rate;
    do @(posedge clk); while (!in_ch.ready);
    predict_command(c, s, tot, rate);
    sent_items++;
  endtask

  task automatic send_start(logic [31:0] tot, logic [31:0] rate);
    send_cmd(CMD_START, pick_sample(), tot, rate);
  endtask

  task automatic send_write(logic [15:0] s);
    send_cmd(CMD_WRITE, s, pick_word(), pick_word());
  endtask

  task automatic send_plain(logic [2:0] c);
    send_cmd(c, pick_sample(), pick_word(), pick_word());
  endtask

  // drop valid and wait for the block to go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    logic [31:0] want;
    case (idx)
      REG_RATE:   want = value & 32'h3ffff;
      REG_PREBUF: want = value & 32'h1ffff;
      default:    want = value & 32'h7fff;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_RATE:   sup_rate    = want[17:0];
      REG_PREBUF: prebuf_need = want[16:0];
      REG_LOUD:   loud_min    = want[14:0];
      default:    quiet_min   = want[14:0];
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want && count_mismatch())
      $display("register %0d read back: expected %h, got %h", idx, want, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_all(logic [31:0] rate, logic [31:0] prebuf, logic [31:0] loud,
                         logic [31:0] quiet);
    settle();
    cfg_write(REG_RATE, rate);
    cfg_write(REG_PREBUF, prebuf);
    cfg_write(REG_LOUD, loud);
    cfg_write(REG_QUIET, quiet);
  endtask

  task automatic test_start_checks();
    send_start(UNKNOWN_LEN, rate_now() - 1);
    send_start(UNKNOWN_LEN, 32'hffff_ffff);
    send_start(32'd0, rate_now());
    send_start(32'(RING) + 1, rate_now());
    send_write(16'h1234);
    send_plain(CMD_FINISH);
    send_plain(CMD_PULL);
    send_plain(3'd6);
    send_plain(3'd7);
    send_start(32'(RING), rate_now());
    send_start(UNKNOWN_LEN, rate_now());
    send_write(16'h7fff);
    send_write(16'h8000);
    send_write(16'h0000);
    send_write(16'hffff);
    send_write(16'h0001);
    send_plain(CMD_PULL);
    send_plain(CMD_FINISH);
    send_write(16'h5555);
    send_plain(CMD_PULL);
    send_plain(CMD_PULL);
    send_plain(CMD_POLL);
    send_plain(CMD_POLL);
  endtask

  task automatic test_known_length();
    send_start(32'd3, rate_now());
    send_write(16'd1000);
    send_write(-16'sd950);
    send_write(16'd10);
    send_write(16'd20);
    send_plain(CMD_PULL);
    send_plain(CMD_FINISH);
    send_plain(CMD_PULL);
    send_plain(CMD_PULL);
    send_plain(CMD_STOP);
    send_start(32'd4, rate_now());
    send_write(16'd7);
    send_plain(CMD_FINISH);
    send_start(UNKNOWN_LEN, rate_now());
    send_plain(CMD_FINISH);
    send_plain(CMD_PULL);
    send_plain(CMD_POLL);
  endtask

  task automatic test_zero_prebuffer();
    settle();
    cfg_write(REG_PREBUF, 32'd0);
    send_start(UNKNOWN_LEN, rate_now());
    send_plain(CMD_PULL);
    send_plain(CMD_PULL);
    send_write(16'd300);
    send_write(16'hfc00);
    send_plain(CMD_PULL);
    send_plain(CMD_PULL);
    send_plain(CMD_STOP);
    send_start(UNKNOWN_LEN, rate_now());
    send_plain(CMD_FINISH);
    send_plain(CMD_PULL);
    send_plain(CMD_POLL);
    settle();
    cfg_write(REG_PREBUF, 32'(PREBUF_RST));
  endtask

  task automatic run_streams(int n_items);
    int          goal;
    int          k;
    logic [31:0] tot;
    logic [31:0] rate;
    goal = sent_items + n_items;
    while (sent_items < goal) begin
      if ($urandom_range(99) < 12) begin
        send_cmd(3'($urandom_range(7)), pick_sample(), pick_word(), pick_word());
      end else begin
        rate = ($urandom_range(9) == 0) ? $urandom : rate_now();
        case ($urandom_range(5))
          0, 1, 2: tot = UNKNOWN_LEN;
          3, 4:    tot = 32'($urandom_range(48, 1));
          default: tot = ($urandom_range(1) == 0) ? 32'd0 : $urandom;
        endcase
        send_start(tot, rate);
        k = $urandom_range(30);
        for (int j = 0; j < k; j++) begin
          if ($urandom_range(4) == 0) send_plain(CMD_PULL);
          send_write(pick_sample());
        end
        if ($urandom_range(4) != 0) send_plain(CMD_FINISH);
        else send_plain(CMD_STOP);
        repeat (3) send_plain(CMD_PULL);
        send_plain(CMD_POLL);
      end
    end
  endtask

  task automatic test_random_settings();
    cfg_all(32'd192000, 32'd1, 32'd0, 32'd0);
    run_streams(15);
    cfg_all(32'd1, 32'd65536, 32'd32767, 32'd32767);
    run_streams(15);
    cfg_all(32'hffff_ffff, 32'($urandom_range(40, 1)), 32'($urandom_range(32767)),
            32'($urandom_range(32767)));
    no_idle = 1'b1;
    run_streams(15);
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    cfg_all(32'(RATE_RST), 32'd24, 32'(LOUD_RST), 32'(QUIET_RST));
    holds_asked++;
    send_start(UNKNOWN_LEN, rate_now());
    repeat (34) send_write(pick_sample());
    repeat (2) send_plain(CMD_PULL);
  endtask

  // result checker
  always @(posedge clk) begin
    playback_result_t got;
    playback_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status      = out_ch.status;
      got.completion  = out_ch.completion_event;
      got.frame_valid = out_ch.frame_valid;
      got.frame       = out_ch.frame_sample;
      got.last        = out_ch.last;
      got.level       = out_ch.mouth_level;
      got.state       = out_ch.stream_state;
      got.active      = out_ch.active;
      got.underruns   = out_ch.underruns;
      if (expected_results.size() == 0) begin
        if (count_mismatch())
          $display("unexpected result: %s", show(got));
      end else begin
        want = expected_results.pop_front();
        if (got !== want && count_mismatch()) begin
          $display("expected: %s", show(want));
          $display("actual:   %s", show(got));
        end
      end
    end
  end

  // result receiver
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (holds_granted != holds_asked) begin
      holds_granted <= holds_granted + 1;
      hold_left     <= HOLD_CYCLES;
      out_ch.ready  <= 1'b0;
    end else begin
      out_ch.ready <= no_idle || ($urandom_range(99) >= 7);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || psel || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL audio_playback_buffer_controller");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.command       = CMD_POLL;
    in_ch.sample        = '0;
    in_ch.total_samples = '0;
    in_ch.sample_rate   = '0;
    out_ch.ready        = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    reset_prediction();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_start_checks();
    test_known_length();
    test_zero_prebuffer();
    test_random_settings();
    test_backpressure();
    settle();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS audio_playback_buffer_controller");
    end else begin
      $display("FAIL audio_playback_buffer_controller");
    end
    $finish;
  end

endmodule
